// ===== src/mbrr_pkg.sv =====
// Shared constants and types for the mono bitmap row repacker.
`timescale 1ns / 1ps

package mbrr_pkg;

	// Field and register widths
	localparam int BYTE_W = 8;
	localparam int DIM_W  = 7;
	localparam int DIM_MAX = (1 << DIM_W) - 1;

	// Most result bytes a single source byte may produce
	localparam int RES_CAP = 64;
	localparam int ZCNT_W  = $clog2(RES_CAP + 1);

	// Default glyph size limits
	localparam int MAX_WIDTH_DEF  = 64;
	localparam int MAX_HEIGHT_DEF = 64;

	// Register indexes on the configuration port
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	// Reset value of both glyph dimensions
	localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(8);

	// Output bytes owed for one source byte: a packed byte, a flushed
	// partial byte and a run of zero bytes, in that order
	typedef struct packed {
		logic                data_vld;
		logic [BYTE_W-1:0]   data;
		logic                flush_vld;
		logic [BYTE_W-1:0]   flush;
		logic [ZCNT_W-1:0]   zeros;
		logic                last;
	} desc_t;

endpackage

// ===== src/mbrr_unpack.sv =====
// Pixel extraction, bit accumulation and glyph position tracking.
`timescale 1ns / 1ps

module mbrr_unpack import mbrr_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic [BYTE_W-1:0] src_byte,
	input  logic [DIM_W-1:0]  width_q,
	input  logic [DIM_W-1:0]  height_q,
	output desc_t             desc
);

	// Effective limits: the registers cannot exceed DIM_MAX
	localparam int W_EFF  = (MAX_WIDTH > DIM_MAX) ? DIM_MAX : MAX_WIDTH;
	localparam int H_EFF  = (MAX_HEIGHT > DIM_MAX) ? DIM_MAX : MAX_HEIGHT;
	localparam int HB_MAX = (W_EFF + 7) / 8;
	localparam int COL_W  = $clog2(HB_MAX + 1);
	localparam int ROW_W  = $clog2(H_EFF + 1);
	localparam int OC_W   = $clog2(HB_MAX * H_EFF + 1);
	localparam int PW     = (COL_W + 3 > DIM_W) ? COL_W + 3 : DIM_W;
	localparam logic [DIM_W-1:0] W_LIM = DIM_W'(W_EFF);
	localparam logic [DIM_W-1:0] H_LIM = DIM_W'(H_EFF);

	// Glyph state
	logic [6:0]       acc_q;
	logic [2:0]       cnt_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [OC_W-1:0]  oc_q;

	logic [DIM_W-1:0]  w, h;
	logic [DIM_W:0]    w_round;
	logic [COL_W-1:0]  hb;
	logic [OC_W-1:0]   total;
	logic [PW-1:0]     first_x, w_x, rem;
	logic [3:0]        npix;
	logic [7:0]        rev;
	logic [7:0]        pix;
	logic [14:0]       accum2;
	logic [3:0]        cnt2;
	logic [2:0]        cnt3;
	logic              e0;
	logic [7:0]        e0_byte;
	logic [6:0]        acc3;
	logic [14:0]       flush_wide;
	logic              fl;
	logic [COL_W-1:0]  col_n;
	logic [ROW_W-1:0]  row_n;
	logic              row_end, glyph_end;
	logic [OC_W:0]     oc_after;
	logic [OC_W:0]     zneed;
	logic [ZCNT_W-1:0] cap;
	logic [ZCNT_W-1:0] zeros;

	// Clamp dimensions and derive row bytes and glyph byte total
	always_comb begin
		w = (width_q == '0) ? DIM_W'(1) : ((width_q > W_LIM) ? W_LIM : width_q);
		h = (height_q == '0) ? DIM_W'(1) : ((height_q > H_LIM) ? H_LIM : height_q);
		w_round = {1'b0, w} + (DIM_W+1)'(7);
		hb = COL_W'(w_round >> 3);
		total = OC_W'(hb) * OC_W'(h);
	end

	// Pixels of this byte that fall inside the row
	always_comb begin
		first_x = PW'({col_q, 3'b000});
		w_x = PW'(w);
		rem = w_x - first_x;
		npix = 4'd0;
		if (first_x < w_x) begin
			npix = (rem >= PW'(8)) ? 4'd8 : rem[3:0];
		end
	end

	// Reverse bit order so the leftmost pixel leads, then append
	always_comb begin
		for (int i = 0; i < 8; i++) begin
			rev[i] = src_byte[7-i];
		end
		pix = rev >> (4'd8 - npix);
		accum2 = (15'(acc_q) << npix) | 15'(pix);
		cnt2 = {1'b0, cnt_q} + npix;
		e0 = cnt2[3];
		cnt3 = cnt2[2:0];
		e0_byte = 8'(accum2 >> cnt3);
		acc3 = accum2[6:0] & 7'((8'd1 << cnt3) - 8'd1);
		fl = (cnt3 != 3'd0);
		flush_wide = 15'(acc3) << (4'd8 - {1'b0, cnt3});
	end

	// Row and glyph end detection, zero fill length
	always_comb begin
		col_n = col_q + COL_W'(1);
		row_n = row_q + ROW_W'(1);
		row_end = (col_n >= hb);
		glyph_end = row_end && (row_n >= ROW_W'(h));
		oc_after = (OC_W+1)'(oc_q) + (OC_W+1)'(e0) + (OC_W+1)'(fl);
		zneed = ((OC_W+1)'(total) > oc_after) ? ((OC_W+1)'(total) - oc_after) : '0;
		cap = ZCNT_W'(RES_CAP) - ZCNT_W'(e0) - ZCNT_W'(fl);
		zeros = (zneed > (OC_W+1)'(cap)) ? cap : ZCNT_W'(zneed);
		// Nothing at all to give at glyph end: one zero byte
		if (!e0 && !fl && zeros == '0) begin
			zeros = ZCNT_W'(1);
		end
	end

	// Transaction descriptor for the output side
	always_comb begin
		desc.data_vld  = e0;
		desc.data      = e0_byte;
		desc.flush_vld = glyph_end && fl;
		desc.flush     = flush_wide[7:0];
		desc.zeros     = glyph_end ? zeros : '0;
		desc.last      = glyph_end;
	end

	// State update on each accepted source byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			cnt_q <= '0;
			col_q <= '0;
			row_q <= '0;
			oc_q  <= '0;
		end else if (take) begin
			if (glyph_end) begin
				acc_q <= '0;
				cnt_q <= '0;
				col_q <= '0;
				row_q <= '0;
				oc_q  <= '0;
			end else begin
				acc_q <= acc3;
				cnt_q <= cnt3;
				oc_q  <= oc_q + OC_W'(e0);
				if (row_end) begin
					col_q <= '0;
					row_q <= row_n;
				end else begin
					col_q <= col_n;
				end
			end
		end
	end

endmodule

// ===== src/mbrr_emit.sv =====
// Descriptor stage and output register: one byte per cycle when ready.
`timescale 1ns / 1ps

module mbrr_emit import mbrr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              src_valid,
	output logic              src_ready,
	output logic              take,
	input  desc_t             desc,
	output logic              res_valid,
	input  logic              res_ready,
	output logic [BYTE_W-1:0] packed_byte,
	output logic              glyph_last
);

	logic  d_vld_s1;
	desc_t d_s1;
	logic  res_valid_q;
	logic  [BYTE_W-1:0] byte_q;
	logic  last_q;

	logic              free_out, pop, done, rem_after, desc_any;
	logic [BYTE_W-1:0] cur_byte;

	// Pick the next byte owed by the held descriptor
	always_comb begin
		if (d_s1.data_vld) begin
			cur_byte  = d_s1.data;
			rem_after = d_s1.flush_vld || (d_s1.zeros != '0);
		end else if (d_s1.flush_vld) begin
			cur_byte  = d_s1.flush;
			rem_after = (d_s1.zeros != '0);
		end else begin
			cur_byte  = '0;
			rem_after = (d_s1.zeros > ZCNT_W'(1));
		end
		free_out = !res_valid_q || res_ready;
		pop      = d_vld_s1 && free_out;
		done     = pop && !rem_after;
		desc_any = desc.data_vld || desc.flush_vld || (desc.zeros != '0);
	end

	assign src_ready = !d_vld_s1 || done;
	assign take      = src_valid && src_ready;

	// Descriptor valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_vld_s1 <= 1'b0;
		end else if (take) begin
			d_vld_s1 <= desc_any;
		end else if (done) begin
			d_vld_s1 <= 1'b0;
		end
	end

	// Descriptor payload: load, or retire the piece just sent
	always_ff @(posedge clk) begin
		if (take) begin
			d_s1 <= desc;
		end else if (pop) begin
			if (d_s1.data_vld) begin
				d_s1.data_vld <= 1'b0;
			end else if (d_s1.flush_vld) begin
				d_s1.flush_vld <= 1'b0;
			end else begin
				d_s1.zeros <= d_s1.zeros - ZCNT_W'(1);
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (pop) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			byte_q <= cur_byte;
			last_q <= d_s1.last && !rem_after;
		end
	end

	assign res_valid   = res_valid_q;
	assign packed_byte = byte_q;
	assign glyph_last  = last_q;

endmodule

// ===== src/mono_bitmap_row_repacker.sv =====
// Top level of the mono bitmap row repacker: config registers and the two stages.
//
//  channel   handshake               payload
//  source    src_valid / src_ready   src_byte
//  result    res_valid / res_ready   packed_byte, glyph_last
//  config    cfg_we                  cfg_index, cfg_data
//
// One source byte is taken per cycle while src_ready is high; results pass
// through the descriptor and output registers. A byte that closes a glyph may
// owe up to 64 result bytes; the descriptor stage sends them one per cycle and
// holds src_ready low meanwhile. A stalled result side backs up through both
// registers. arst_n clears all glyph state; both dimensions reset to 8.
`timescale 1ns / 1ps

module mono_bitmap_row_repacker import mbrr_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [DIM_W-1:0]  cfg_data,
	input  logic              src_valid,
	output logic              src_ready,
	input  logic [BYTE_W-1:0] src_byte,
	output logic              res_valid,
	input  logic              res_ready,
	output logic [BYTE_W-1:0] packed_byte,
	output logic              glyph_last
);

	logic [DIM_W-1:0] width_q, height_q;
	logic             take;
	desc_t            desc;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_RESET;
			height_q <= DIM_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	mbrr_unpack #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_unpack (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.src_byte (src_byte),
		.width_q  (width_q),
		.height_q (height_q),
		.desc     (desc)
	);

	mbrr_emit u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.src_valid   (src_valid),
		.src_ready   (src_ready),
		.take        (take),
		.desc        (desc),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.packed_byte (packed_byte),
		.glyph_last  (glyph_last)
	);

endmodule

// ===== tb/mbrr_repack_checker.sv =====
// Checker for the row repacker: predicts packed bytes and compares each result transaction.
`timescale 1ns / 1ps

module mbrr_repack_checker import mbrr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [DIM_W-1:0]  cfg_data,
	input  logic              src_valid,
	input  logic              src_ready,
	input  logic [BYTE_W-1:0] src_byte,
	input  logic              res_valid,
	input  logic              res_ready,
	input  logic [BYTE_W-1:0] packed_byte,
	input  logic              glyph_last,
	input  logic              wrap_up,
	output int                fail_count,
	output int                pending
);

	typedef struct packed {
		logic [BYTE_W-1:0] pix;
		logic              last;
	} owed_t;

	// Bytes predicted but not yet seen, oldest first
	owed_t owed_bytes[$];

	// Shadow of the dimension registers and the glyph walk
	logic [DIM_W-1:0]  width_reg  = DIM_RESET;
	logic [DIM_W-1:0]  height_reg = DIM_RESET;
	logic [14:0]       pix_acc    = '0;
	logic [3:0]        pix_cnt    = '0;
	logic [2:0]        col_idx    = '0;
	logic [5:0]        row_idx    = '0;
	logic [9:0]        glyph_out  = '0;
	logic [BYTE_W-1:0] step_buf [RES_CAP];
	int                step_n;
	bit                wrapped    = 1'b0;

	initial begin
		fail_count = 0;
		pending    = 0;
	end

	task automatic flag(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		fail_count++;
	endtask

	// Zero reads as one, anything past the limit as the limit
	function automatic int clamp_dim(input logic [DIM_W-1:0] v, input int cap);
		if (v == '0)
			return 1;
		if (int'(v) > cap)
			return cap;
		return int'(v);
	endfunction

	// Bytes beyond the per-transaction cap are dropped, not counted
	task automatic emit_byte(input logic [BYTE_W-1:0] b);
		if (step_n < RES_CAP) begin
			step_buf[step_n] = b;
			step_n++;
			glyph_out = glyph_out + 10'd1;
		end
	endtask

	// One source byte: gather its pixels, emit what is complete, close row and glyph
	task automatic repack_src_byte(input logic [BYTE_W-1:0] src);
		int    w, h, row_bytes, total, first, npix, nxt, i, k;
		bit    any, ends;
		owed_t e;
		w         = clamp_dim(width_reg, MAX_WIDTH_DEF);
		h         = clamp_dim(height_reg, MAX_HEIGHT_DEF);
		row_bytes = (w + 7) / 8;
		total     = row_bytes * h;
		first     = int'(col_idx) * 8;
		npix      = 0;
		step_n    = 0;
		any       = 1'b0;
		ends      = 1'b0;
		// columns wholly past the width add nothing
		if (first < w)
			npix = (w - first >= 8) ? 8 : w - first;
		for (i = 0; i < npix; i++) begin
			pix_acc = {pix_acc[13:0], src[i]};
			pix_cnt = pix_cnt + 4'd1;
		end
		if (pix_cnt >= 4'd8) begin
			pix_cnt = pix_cnt - 4'd8;
			emit_byte(BYTE_W'(pix_acc >> pix_cnt));
			pix_acc = pix_acc & ((15'd1 << pix_cnt) - 15'd1);
		end
		// row and glyph ends use >= so a shrunk size closes at once
		nxt = int'(col_idx) + 1;
		if (nxt < row_bytes) begin
			col_idx = 3'(nxt);
		end else begin
			col_idx = '0;
			nxt = int'(row_idx) + 1;
			if (nxt < h) begin
				row_idx = 6'(nxt);
			end else begin
				ends = 1'b1;
				if (pix_cnt != 4'd0) begin
					emit_byte(BYTE_W'(pix_acc << (4'd8 - pix_cnt)));
					any = 1'b1;
				end
				while (int'(glyph_out) < total && step_n < RES_CAP) begin
					emit_byte('0);
					any = 1'b1;
				end
				// a glyph always ends on a marked byte, even with nothing owed
				if (!any && step_n == 0)
					emit_byte('0);
				pix_acc   = '0;
				pix_cnt   = '0;
				row_idx   = '0;
				glyph_out = '0;
			end
		end
		for (k = 0; k < step_n; k++) begin
			e.pix  = step_buf[k];
			e.last = ends && (k == step_n - 1);
			owed_bytes.push_back(e);
		end
	endtask

	// Sample both channels and the config port at each rising edge
	always @(posedge clk or negedge arst_n) begin : watch
		owed_t head;
		if (!arst_n) begin
			width_reg  = DIM_RESET;
			height_reg = DIM_RESET;
			pix_acc    = '0;
			pix_cnt    = '0;
			col_idx    = '0;
			row_idx    = '0;
			glyph_out  = '0;
			owed_bytes.delete();
		end else begin
			if (src_valid && src_ready)
				repack_src_byte(src_byte);
			if (cfg_we) begin
				case (cfg_index)
					REG_WIDTH:  width_reg  = cfg_data;
					REG_HEIGHT: height_reg = cfg_data;
					default: ;
				endcase
			end
			if (res_valid && res_ready) begin
				if (owed_bytes.size() == 0) begin
					flag($sformatf("unexpected result %02h, glyph_last %0b",
						packed_byte, glyph_last));
				end else begin
					head = owed_bytes.pop_front();
					if (packed_byte !== head.pix)
						flag($sformatf("packed_byte %02h, predicted %02h",
							packed_byte, head.pix));
					if (glyph_last !== head.last)
						flag($sformatf("glyph_last %0b, predicted %0b on byte %02h",
							glyph_last, head.last, head.pix));
				end
			end
			// whatever is still owed at the end never came
			if (wrap_up && !wrapped) begin
				wrapped = 1'b1;
				if (owed_bytes.size() != 0)
					flag($sformatf("%0d predicted bytes never arrived", owed_bytes.size()));
			end
		end
		pending = owed_bytes.size();
	end

endmodule

// ===== tb/tb_mono_bitmap_row_repacker.sv =====
// Testbench top for the mono bitmap row repacker: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_mono_bitmap_row_repacker;
	import mbrr_pkg::*;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              cfg_we    = 1'b0;
	logic              cfg_index = REG_WIDTH;
	logic [DIM_W-1:0]  cfg_data  = '0;
	logic              src_valid = 1'b0;
	logic [BYTE_W-1:0] src_byte  = '0;
	logic              res_ready = 1'b0;
	logic              wrap_up   = 1'b0;
	logic              src_ready;
	logic              res_valid;
	logic [BYTE_W-1:0] packed_byte;
	logic              glyph_last;
	int                fail_count;
	int                pending;

	// Idle odds in percent on each side
	int src_idle_pct  = 26;
	int res_stall_pct = 53;

	// Dimensions as last written
	logic [DIM_W-1:0] cur_w = DIM_RESET;
	logic [DIM_W-1:0] cur_h = DIM_RESET;

	always #1 clk = ~clk;

	// Result side back-pressure
	always @(negedge clk)
		res_ready <= ($urandom_range(0, 99) >= res_stall_pct);

	mono_bitmap_row_repacker u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.src_valid   (src_valid),
		.src_ready   (src_ready),
		.src_byte    (src_byte),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.packed_byte (packed_byte),
		.glyph_last  (glyph_last)
	);

	mbrr_repack_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.src_valid   (src_valid),
		.src_ready   (src_ready),
		.src_byte    (src_byte),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.packed_byte (packed_byte),
		.glyph_last  (glyph_last),
		.wrap_up     (wrap_up),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	// Hard stop well past the slowest legal run
	initial begin : watchdog
		#1000000;
		$display("tb_mono_bitmap_row_repacker: done, errors");
		$finish;
	end

	// Source bytes in one glyph with the given register values
	function automatic int glyph_items(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
		int ew, eh;
		ew = (w == '0) ? 1 : ((int'(w) > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(w));
		eh = (h == '0) ? 1 : ((int'(h) > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : int'(h));
		return ((ew + 7) / 8) * eh;
	endfunction

	// One source transaction, with random idle cycles in front
	task automatic send_src(input logic [BYTE_W-1:0] b);
		@(negedge clk);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			src_valid <= 1'b0;
			@(negedge clk);
		end
		src_valid <= 1'b1;
		src_byte  <= b;
		@(posedge clk);
		while (!src_ready)
			@(posedge clk);
	endtask

	// Hold the source back until every predicted byte has come out
	task automatic drain_results;
		@(negedge clk);
		src_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	// Register writes only once the block has gone quiet
	task automatic set_dims(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
			input bit wr_w, input bit wr_h);
		drain_results();
		repeat (8) @(negedge clk);
		if (wr_w) begin
			@(negedge clk);
			cfg_we    <= 1'b1;
			cfg_index <= REG_WIDTH;
			cfg_data  <= w;
			cur_w = w;
		end
		if (wr_h) begin
			@(negedge clk);
			cfg_we    <= 1'b1;
			cfg_index <= REG_HEIGHT;
			cfg_data  <= h;
			cur_h = h;
		end
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin : stimulus
		logic [BYTE_W-1:0] patt [8];
		logic [DIM_W-1:0]  w, h;
		int                sent, len, glyphs, k;
		bit                wr_w, wr_h;

		patt = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'hAA, 8'h55, 8'h0F, 8'hF0};

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset size 8x8: each byte comes back bit-reversed
		for (k = 0; k < 8; k++)
			send_src(patt[k]);

		// width shrunk under a pending column: nothing owed, lone zero byte ends the glyph
		set_dims(7'd16, 7'd1, 1'b1, 1'b1);
		send_src(8'h3C);
		set_dims(7'd8, 7'd0, 1'b1, 1'b0);
		send_src(8'hFF);

		// narrow rows, then a full-width last row: zero fill runs into the cap
		set_dims(7'd1, 7'd10, 1'b1, 1'b1);
		repeat (9) send_src(BYTE_W'($urandom));
		set_dims(7'd64, 7'd0, 1'b1, 1'b0);
		repeat (8) send_src(BYTE_W'($urandom));

		// random glyph sizes, mostly whole glyphs, some cut short
		sent = 0;
		while (sent < 380) begin
			if (sent < 127) begin
				src_idle_pct  = 26;
				res_stall_pct = 53;
			end else if (sent < 254) begin
				src_idle_pct  = 53;
				res_stall_pct = 26;
			end else begin
				src_idle_pct  = 0;
				res_stall_pct = 0;
			end

			case ($urandom_range(0, 11))
				0: w = '0;
				1: w = 7'd1;
				2: w = 7'd127;
				3: w = 7'd64;
				4: w = DIM_W'($urandom_range(65, 126));
				default: w = DIM_W'($urandom_range(2, 20));
			endcase
			// wide rows keep the glyph short; tall glyphs only with one-byte rows
			if (glyph_items(w, 7'd1) > 1) begin
				h = DIM_W'($urandom_range(0, 6));
			end else begin
				case ($urandom_range(0, 11))
					0: h = '0;
					1: h = 7'd127;
					2: h = 7'd64;
					default: h = DIM_W'($urandom_range(1, 12));
				endcase
			end
			wr_w = 1'b1;
			wr_h = 1'b1;
			case ($urandom_range(0, 9))
				0: wr_w = 1'b0;
				1: wr_h = 1'b0;
				default: ;
			endcase
			set_dims(w, h, wr_w, wr_h);

			len    = glyph_items(cur_w, cur_h);
			glyphs = (len > 24) ? 1 : $urandom_range(1, 3);
			len    = len * glyphs;
			// a cut glyph leaves the next size change landing mid-glyph
			if ($urandom_range(0, 3) == 0 && len > 1)
				len = $urandom_range(1, len - 1);
			// stop near the item budget
			if (len > 380 - sent)
				len = 380 - sent;
			repeat (len) begin
				if ($urandom_range(0, 39) == 0)
					drain_results();
				send_src(BYTE_W'($urandom));
				sent++;
			end
		end

		drain_results();
		repeat (8) @(negedge clk);
		wrap_up <= 1'b1;
		repeat (2) @(negedge clk);
		if (fail_count == 0)
			$display("tb_mono_bitmap_row_repacker: done, clean");
		else
			$display("tb_mono_bitmap_row_repacker: done, errors");
		$finish;
	end

endmodule

// ===== files.f =====
src/mbrr_pkg.sv
src/mbrr_unpack.sv
src/mbrr_emit.sv
src/mono_bitmap_row_repacker.sv
tb/mbrr_repack_checker.sv
tb/tb_mono_bitmap_row_repacker.sv
